@@ design/nae_pkg.sv @@
// ----------------------------------------------------------------------------
// nae_pkg
// Shared constants, item codes, sequencer states and activation clamps for the
// accumulator and evaluator unit.
// ----------------------------------------------------------------------------
package nae_pkg;

    localparam int ACCUM_SIZE_DEF  = 128;
    localparam int HIDDEN_SIZE_DEF = 16;
    localparam int PIECE_KINDS     = 12;
    localparam int SQUARES         = 64;
    localparam int HALF_KINDS      = 6;

    localparam logic [3:0] F_ADD    = 4'd0;
    localparam logic [3:0] F_REMOVE = 4'd1;
    localparam logic [3:0] F_MOVE   = 4'd2;
    localparam logic [3:0] F_RESET  = 4'd3;
    localparam logic [3:0] F_EVAL   = 4'd4;
    localparam logic [3:0] F_WR_FW  = 4'd5;
    localparam logic [3:0] F_WR_FB  = 4'd6;
    localparam logic [3:0] F_WR_HW  = 4'd7;
    localparam logic [3:0] F_WR_HB  = 4'd8;
    localparam logic [3:0] F_WR_OW  = 4'd9;
    localparam logic [3:0] F_WR_OB  = 4'd10;

    localparam logic [5:0] RANK_FLIP = 6'd56;
    localparam logic [6:0] ACT_MAX   = 7'd127;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_UPD,
        S_EVAL,
        S_EWAIT,
        S_OUT
    } t_state;

    function automatic logic [6:0] clamp16(input logic [15:0] x);
        logic [6:0] r;
        if (x[15]) begin
            r = '0;
        end else if (x[14:7] != '0) begin
            r = ACT_MAX;
        end else begin
            r = x[6:0];
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp32(input logic [31:0] x);
        logic [6:0] r;
        if (x[31]) begin
            r = '0;
        end else if (x[30:7] != '0) begin
            r = ACT_MAX;
        end else begin
            r = x[6:0];
        end
        return r;
    endfunction

endpackage

@@ design/nae_ram.sv @@
// ----------------------------------------------------------------------------
// nae_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module nae_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/nnue_accumulator_and_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// nnue_accumulator_and_evaluator_unit
// Two perspective accumulators and network weights in synchronous RAMs, with a
// sequencer that streams one lane or one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
// Add/remove, move and reset to bias each step one accumulator lane per cycle
// through the RAM port. Evaluate steps one MAC per cycle towards the score,
// limited by the single hidden weight read port. Weight writes are taken
// straight from the accepted item. One item at a time. After reset a clearing
// pass zeroes both accumulators; no item is accepted meanwhile.
module nnue_accumulator_and_evaluator_unit #(
    parameter int ACCUM_SIZE  = nae_pkg::ACCUM_SIZE_DEF,
    parameter int HIDDEN_SIZE = nae_pkg::HIDDEN_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_func,
    input  logic [3:0]  i_piece,
    input  logic [5:0]  i_square,
    input  logic [3:0]  i_to_piece,
    input  logic [5:0]  i_to_square,
    input  logic        i_side_to_move,
    input  logic [7:0]  i_lane,
    input  logic [3:0]  i_neuron,
    input  logic signed [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_score
);

    import nae_pkg::*;

    localparam int AW       = $clog2(ACCUM_SIZE);
    localparam int NW       = $clog2(HIDDEN_SIZE);
    localparam int FW_DEPTH = PIECE_KINDS * SQUARES * ACCUM_SIZE;
    localparam int FW_AW    = $clog2(FW_DEPTH);
    localparam int HW_DEPTH = HIDDEN_SIZE * 2 * ACCUM_SIZE;
    localparam int HW_AW    = $clog2(HW_DEPTH);
    localparam logic [AW-1:0] LANE_LAST = AW'(ACCUM_SIZE - 1);
    localparam logic [NW-1:0] NRN_LAST  = NW'(HIDDEN_SIZE - 1);

    t_state r_state, n_state;

    logic          in_acc;
    logic [3:0]    r_func, r_piece, r_tpiece;
    logic [5:0]    r_sq, r_tsq;
    logic          r_stm;
    logic [AW-1:0] r_idx;
    logic [1:0]    r_pass;
    logic          r_half;
    logic [NW-1:0] r_nrn;
    logic [31:0]   r_ob;

    // pass decode
    logic        p_half, p_blk, p_copy, p_sub, p_active;
    logic [3:0]  p_pc, p_opc, p_epc;
    logic [5:0]  p_sq, p_esq;
    logic        upd_issue, ev_issue, clr_we, out_load, upd_end;

    // write-back stage
    logic          r_p_v, r_p_blk, r_p_sub, r_p_copy;
    logic [AW-1:0] r_p_addr;
    // evaluate data stage
    logic          r_e_v, r_e_first, r_e_last, r_e_lastn, r_e_them;
    logic [31:0]   r_sum;
    logic          r_fin_v, r_fin_lastn;
    logic [31:0]   r_fin;
    logic [7:0]    r_fin_ow;
    logic [31:0]   r_acc_out;
    logic          r_ev_done;
    logic          r_o_valid;
    logic [31:0]   r_score;

    // memory ports
    logic [FW_AW-1:0] fw_waddr, fw_raddr;
    logic [HW_AW-1:0] hw_waddr, hw_raddr;
    logic             fw_we, fb_we, hw_we, hb_we, ow_we;
    logic [15:0]      fw_rd, fb_rd, accw_rd, accb_rd, acc_wdata;
    logic [7:0]       hw_rd, ow_rd;
    logic [31:0]      hb_rd;
    logic             accw_we, accb_we;
    logic [AW-1:0]    acc_waddr;

    logic [15:0]        e_acc, u_acc;
    logic [6:0]         e_act, f_act;
    logic signed [15:0] e_prod, f_prod;
    logic [31:0]        e_sum_in, e_sum;

    assign in_acc = i_in_valid && !o_in_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        p_half   = r_pass[1];
        p_blk    = r_pass[0];
        p_pc     = p_half ? r_tpiece : r_piece;
        p_sq     = p_half ? r_tsq : r_sq;
        p_opc    = (p_pc < 4'(HALF_KINDS)) ? p_pc + 4'(HALF_KINDS) : p_pc - 4'(HALF_KINDS);
        p_epc    = p_blk ? p_opc : p_pc;
        p_esq    = p_blk ? (p_sq ^ RANK_FLIP) : p_sq;
        p_copy   = (r_func == F_RESET);
        p_sub    = (r_func == F_REMOVE) || ((r_func == F_MOVE) && !p_half);
        p_active = p_copy ? (r_pass == 2'd0)
                          : ((p_pc < 4'(PIECE_KINDS)) && (!p_half || r_func == F_MOVE));
        upd_end  = (r_pass == 2'd3) && (!p_active || r_idx == LANE_LAST);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_idx == LANE_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        F_ADD, F_REMOVE, F_MOVE, F_RESET: n_state = S_UPD;
                        F_EVAL:                           n_state = S_EVAL;
                        default:                          n_state = S_IDLE;
                    endcase
                end
            end
            S_UPD: begin
                if (upd_end) n_state = S_IDLE;
            end
            S_EVAL: begin
                if (r_idx == LANE_LAST && r_half && r_nrn == NRN_LAST) n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (r_ev_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        clr_we     = (r_state == S_CLR);
        upd_issue  = (r_state == S_UPD) && p_active;
        ev_issue   = (r_state == S_EVAL);
        out_load   = (r_state == S_OUT) && (!r_o_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_pass  <= '0;
            r_half  <= 1'b0;
            r_nrn   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLR: begin
                    r_idx <= (r_idx == LANE_LAST) ? '0 : r_idx + 1'b1;
                end
                S_IDLE: begin
                    r_idx  <= '0;
                    r_pass <= '0;
                    r_half <= 1'b0;
                    r_nrn  <= '0;
                end
                S_UPD: begin
                    if (upd_issue && r_idx != LANE_LAST) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx  <= '0;
                        r_pass <= r_pass + 1'b1;
                    end
                end
                S_EVAL: begin
                    if (r_idx != LANE_LAST) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx  <= '0;
                        r_half <= !r_half;
                        if (r_half) r_nrn <= r_nrn + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // hold the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func   <= i_func;
            r_piece  <= i_piece;
            r_sq     <= i_square;
            r_tpiece <= i_to_piece;
            r_tsq    <= i_to_square;
            r_stm    <= i_side_to_move;
        end
        if (in_acc && i_func == F_WR_OB) begin
            r_ob <= i_value;
        end
    end

    // ---------------- weight writes ----------------
    always_comb begin
        fw_we    = in_acc && (i_func == F_WR_FW) && (i_piece < 4'(PIECE_KINDS))
                   && (32'(i_lane) < 32'(ACCUM_SIZE));
        fb_we    = in_acc && (i_func == F_WR_FB) && (32'(i_lane) < 32'(ACCUM_SIZE));
        hw_we    = in_acc && (i_func == F_WR_HW) && (32'(i_neuron) < 32'(HIDDEN_SIZE))
                   && (32'(i_lane) < 32'(2 * ACCUM_SIZE));
        hb_we    = in_acc && (i_func == F_WR_HB) && (32'(i_neuron) < 32'(HIDDEN_SIZE));
        ow_we    = in_acc && (i_func == F_WR_OW) && (32'(i_neuron) < 32'(HIDDEN_SIZE));
        fw_waddr = FW_AW'((32'(i_piece) * SQUARES + 32'(i_square)) * ACCUM_SIZE
                          + 32'(i_lane));
        hw_waddr = HW_AW'(32'(i_neuron) * (2 * ACCUM_SIZE) + 32'(i_lane));
        fw_raddr = FW_AW'((32'(p_epc) * SQUARES + 32'(p_esq)) * ACCUM_SIZE + 32'(r_idx));
        hw_raddr = HW_AW'((32'(r_nrn) * 2 + 32'(r_half)) * ACCUM_SIZE + 32'(r_idx));
    end

    nae_ram #(.DATA_W(16), .DEPTH(FW_DEPTH)) u_fw (
        .i_clk(i_clk), .i_we(fw_we), .i_waddr(fw_waddr), .i_wdata(i_value[15:0]),
        .i_raddr(fw_raddr), .o_rdata(fw_rd)
    );

    nae_ram #(.DATA_W(16), .DEPTH(ACCUM_SIZE)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_waddr(AW'(i_lane)), .i_wdata(i_value[15:0]),
        .i_raddr(r_idx), .o_rdata(fb_rd)
    );

    nae_ram #(.DATA_W(8), .DEPTH(HW_DEPTH)) u_hw (
        .i_clk(i_clk), .i_we(hw_we), .i_waddr(hw_waddr), .i_wdata(i_value[7:0]),
        .i_raddr(hw_raddr), .o_rdata(hw_rd)
    );

    nae_ram #(.DATA_W(32), .DEPTH(HIDDEN_SIZE)) u_hb (
        .i_clk(i_clk), .i_we(hb_we), .i_waddr(NW'(i_neuron)), .i_wdata(i_value),
        .i_raddr(r_nrn), .o_rdata(hb_rd)
    );

    nae_ram #(.DATA_W(8), .DEPTH(HIDDEN_SIZE)) u_ow (
        .i_clk(i_clk), .i_we(ow_we), .i_waddr(NW'(i_neuron)), .i_wdata(i_value[7:0]),
        .i_raddr(r_nrn), .o_rdata(ow_rd)
    );

    // ---------------- accumulator update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= upd_issue;
        end
        r_p_addr <= r_idx;
        r_p_blk  <= p_blk;
        r_p_sub  <= p_sub;
        r_p_copy <= p_copy;
    end

    always_comb begin
        u_acc     = r_p_blk ? accb_rd : accw_rd;
        if (clr_we) begin
            acc_wdata = '0;
        end else if (r_p_copy) begin
            acc_wdata = fb_rd;
        end else if (r_p_sub) begin
            acc_wdata = u_acc - fw_rd;
        end else begin
            acc_wdata = u_acc + fw_rd;
        end
        acc_waddr = clr_we ? r_idx : r_p_addr;
        accw_we   = clr_we || (r_p_v && (r_p_copy || !r_p_blk));
        accb_we   = clr_we || (r_p_v && (r_p_copy || r_p_blk));
    end

    nae_ram #(.DATA_W(16), .DEPTH(ACCUM_SIZE)) u_accw (
        .i_clk(i_clk), .i_we(accw_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_raddr(r_idx), .o_rdata(accw_rd)
    );

    nae_ram #(.DATA_W(16), .DEPTH(ACCUM_SIZE)) u_accb (
        .i_clk(i_clk), .i_we(accb_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_raddr(r_idx), .o_rdata(accb_rd)
    );

    // ---------------- evaluation ----------------
    always_comb begin
        e_acc    = (r_stm ^ r_e_them) ? accb_rd : accw_rd;
        e_act    = clamp16(e_acc);
        e_prod   = $signed({1'b0, e_act}) * $signed(hw_rd);
        e_sum_in = r_e_first ? hb_rd : r_sum;
        e_sum    = e_sum_in + {{16{e_prod[15]}}, e_prod};
        f_act    = clamp32(r_fin);
        f_prod   = $signed({1'b0, f_act}) * $signed(r_fin_ow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v     <= 1'b0;
            r_fin_v   <= 1'b0;
            r_ev_done <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_e_v     <= ev_issue;
            r_fin_v   <= r_e_v && r_e_last;
            if (r_fin_v && r_fin_lastn) begin
                r_ev_done <= 1'b1;
            end else if (r_state == S_EWAIT) begin
                r_ev_done <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        r_e_first <= (r_idx == '0) && !r_half;
        r_e_last  <= (r_idx == LANE_LAST) && r_half;
        r_e_lastn <= (r_idx == LANE_LAST) && r_half && (r_nrn == NRN_LAST);
        r_e_them  <= r_half;
        if (r_e_v) begin
            r_sum <= e_sum;
        end
        if (r_e_v && r_e_last) begin
            r_fin       <= e_sum;
            r_fin_ow    <= ow_rd;
            r_fin_lastn <= r_e_lastn;
        end
        if (in_acc && i_func == F_EVAL) begin
            r_acc_out <= r_ob;
        end else if (r_fin_v) begin
            r_acc_out <= r_acc_out + {{16{f_prod[15]}}, f_prod};
        end
        if (out_load) begin
            r_score <= r_acc_out;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_score     = r_score;

    // ---------------- assertions ----------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_p_v && r_e_v))
        else $error("update write-back and evaluation data stage overlap");

    a_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v |-> (r_p_addr != r_idx))
        else $error("accumulator read hits lane being written back");

    a_fin_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_v |-> $past(r_e_v))
        else $error("neuron finish without data stage");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_done |-> (r_state == S_EWAIT))
        else $error("evaluation done outside wait state");

endmodule

@@ verif/tb_nnue_accumulator_and_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_nnue_accumulator_and_evaluator_unit
// Self-checking bench: loads every weight that later gets read, runs directed
// and random add/remove/move/reset/evaluate/write items with bursty input and
// patterned output stalls, and checks each score against an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nnue_accumulator_and_evaluator_unit;
    import nae_pkg::*;

    localparam int NACC      = ACCUM_SIZE_DEF;
    localparam int NHID      = HIDDEN_SIZE_DEF;
    localparam int NFW       = PIECE_KINDS * SQUARES * NACC;
    localparam int MAX_CYC   = 8000000;
    localparam int TAIL_CYC  = 4 * NACC + 100;

    typedef struct packed {
        logic        sync;
        logic [3:0]  func;
        logic [3:0]  piece;
        logic [5:0]  square;
        logic [3:0]  to_piece;
        logic [5:0]  to_square;
        logic        stm;
        logic [7:0]  lane;
        logic [3:0]  neuron;
        logic [31:0] value;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_func = '0;
    logic [3:0]  i_piece = '0;
    logic [5:0]  i_square = '0;
    logic [3:0]  i_to_piece = '0;
    logic [5:0]  i_to_square = '0;
    logic        i_side_to_move = 1'b0;
    logic [7:0]  i_lane = '0;
    logic [3:0]  i_neuron = '0;
    logic signed [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [31:0] o_score;

    nnue_accumulator_and_evaluator_unit i_dut (.*);

    always #6 i_clk = ~i_clk;

    logic [15:0] fw_mem [0:NFW-1];
    logic [15:0] fb_mem [0:NACC-1];
    logic [7:0]  hw_mem [0:NHID*2*NACC-1];
    logic [31:0] hb_mem [0:NHID-1];
    logic [7:0]  ow_mem [0:NHID-1];
    logic [31:0] ob_reg;
    logic [15:0] wacc [0:NACC-1];
    logic [15:0] bacc [0:NACC-1];

    t_item       pend_q[$];
    logic [31:0] score_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          sent_cnt = 0;
    int          acc_cnt = 0;
    int          gap = 0;
    int          burst = 8;
    bit          rst_done = 0;
    bit          hold_off = 0;
    int          hold_cnt = 0;
    int          mode = 0;
    int          mode_left = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got), $signed(want),
                 $realtime);
    endtask

    function automatic logic [6:0] act16(input logic [15:0] v);
        if (v[15]) return 7'd0;
        if (v > 16'd127) return 7'd127;
        return v[6:0];
    endfunction

    function automatic logic [6:0] act32(input logic [31:0] v);
        if (v[31]) return 7'd0;
        if (v > 32'd127) return 7'd127;
        return v[6:0];
    endfunction

    task automatic apply_feature(input logic [3:0] pc, input logic [5:0] sq, input bit sub);
        int wb, bb;
        logic [3:0] other;
        if (pc >= PIECE_KINDS) return;
        other = (pc < HALF_KINDS) ? 4'(pc + HALF_KINDS) : 4'(pc - HALF_KINDS);
        wb = (int'(pc) * SQUARES + int'(sq)) * NACC;
        bb = (int'(other) * SQUARES + int'(sq ^ RANK_FLIP)) * NACC;
        for (int i = 0; i < NACC; i++) begin
            wacc[i] = sub ? wacc[i] - fw_mem[wb + i] : wacc[i] + fw_mem[wb + i];
            bacc[i] = sub ? bacc[i] - fw_mem[bb + i] : bacc[i] + fw_mem[bb + i];
        end
    endtask

    function automatic logic [31:0] score_of(input logic stm);
        logic [6:0]  act [0:2*NACC-1];
        logic [31:0] sum, res;
        for (int i = 0; i < NACC; i++) begin
            act[i]        = act16(stm ? bacc[i] : wacc[i]);
            act[i + NACC] = act16(stm ? wacc[i] : bacc[i]);
        end
        res = ob_reg;
        for (int n = 0; n < NHID; n++) begin
            sum = hb_mem[n];
            for (int j = 0; j < 2 * NACC; j++)
                sum = sum + 32'(int'(act[j]) * int'($signed(hw_mem[n * 2 * NACC + j])));
            res = res + 32'(int'(act32(sum)) * int'($signed(ow_mem[n])));
        end
        return res;
    endfunction

    task automatic predict(input t_item it);
        case (it.func)
            F_ADD:    apply_feature(it.piece, it.square, 0);
            F_REMOVE: apply_feature(it.piece, it.square, 1);
            F_MOVE: begin
                apply_feature(it.piece, it.square, 1);
                apply_feature(it.to_piece, it.to_square, 0);
            end
            F_RESET: begin
                for (int i = 0; i < NACC; i++) begin
                    wacc[i] = fb_mem[i];
                    bacc[i] = fb_mem[i];
                end
            end
            F_EVAL:   score_q.push_back(score_of(it.stm));
            F_WR_FW: begin
                if (it.piece < PIECE_KINDS && it.lane < NACC)
                    fw_mem[(int'(it.piece) * SQUARES + int'(it.square)) * NACC + int'(it.lane)]
                        = it.value[15:0];
            end
            F_WR_FB:  if (it.lane < NACC) fb_mem[it.lane] = it.value[15:0];
            F_WR_HW:  hw_mem[int'(it.neuron) * 2 * NACC + int'(it.lane)] = it.value[7:0];
            F_WR_HB:  hb_mem[it.neuron] = it.value;
            F_WR_OW:  ow_mem[it.neuron] = it.value[7:0];
            F_WR_OB:  ob_reg = it.value;
            default: ;
        endcase
    endtask

    function automatic t_item noise_item();
        t_item it;
        it.sync      = 1'b0;
        it.func      = 4'($urandom);
        it.piece     = 4'($urandom);
        it.square    = 6'($urandom);
        it.to_piece  = 4'($urandom);
        it.to_square = 6'($urandom);
        it.stm       = 1'($urandom);
        it.lane      = 8'($urandom);
        it.neuron    = 4'($urandom);
        it.value     = $urandom;
        return it;
    endfunction

    function automatic logic [5:0] loaded_sq();
        case ($urandom_range(0, 3))
            0: return 6'd0;
            1: return 6'd7;
            2: return 6'd56;
            default: return 6'd63;
        endcase
    endfunction

    function automatic t_item op_item(input logic [3:0] f, input logic [3:0] pc,
                                      input logic [5:0] sq, input logic [3:0] tp,
                                      input logic [5:0] tsq, input logic stm);
        t_item it;
        it = noise_item();
        it.func = f; it.piece = pc; it.square = sq;
        it.to_piece = tp; it.to_square = tsq; it.stm = stm;
        return it;
    endfunction

    function automatic t_item wr_item(input logic [3:0] f, input logic [3:0] pc,
                                      input logic [5:0] sq, input logic [7:0] ln,
                                      input logic [3:0] nr, input logic [31:0] v);
        t_item it;
        it = noise_item();
        it.func = f; it.piece = pc; it.square = sq;
        it.lane = ln; it.neuron = nr; it.value = v;
        return it;
    endfunction

    function automatic t_item rand_item();
        int r;
        logic [3:0] pc, tp;
        r  = $urandom_range(0, 99);
        pc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
        tp = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
        if (r < 15) return op_item(F_ADD, pc, pc < 12 ? loaded_sq() : 6'($urandom), 0, 0, 0);
        if (r < 28) return op_item(F_REMOVE, pc, pc < 12 ? loaded_sq() : 6'($urandom), 0, 0, 0);
        if (r < 45) return op_item(F_MOVE, pc, pc < 12 ? loaded_sq() : 6'($urandom),
                                   tp, tp < 12 ? loaded_sq() : 6'($urandom), 0);
        if (r < 50) return op_item(F_RESET, pc, 0, 0, 0, 0);
        if (r < 60) return op_item(F_EVAL, 0, 0, 0, 0, 1'($urandom));
        if (r < 70) return wr_item(F_WR_FW, 4'($urandom), 6'($urandom), 8'($urandom), 0,
                                   $urandom);
        if (r < 75) return wr_item(F_WR_FB, 0, 0, 8'($urandom), 0, $urandom);
        if (r < 85) return wr_item(F_WR_HW, 0, 0, 8'($urandom), 4'($urandom), $urandom);
        if (r < 88) return wr_item(F_WR_HB, 0, 0, 0, 4'($urandom), $urandom_range(0, 4000) - 2000);
        if (r < 92) return wr_item(F_WR_OW, 0, 0, 0, 4'($urandom), $urandom);
        if (r < 94) return wr_item(F_WR_OB, 0, 0, 0, 0, $urandom);
        return op_item(4'($urandom_range(11, 15)), 4'($urandom), 6'($urandom), 4'($urandom),
                       6'($urandom), 1'($urandom));
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (rst_done && !(i_in_valid && acc_cnt != sent_cnt)) begin
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                gap--;
            end else if (pend_q.size() > 0 && pend_q[0].sync) begin
                i_in_valid <= 1'b0;
                if (score_q.size() == 0) void'(pend_q.pop_front());
            end else if (pend_q.size() > 0) begin
                t_item it;
                it = pend_q.pop_front();
                i_func <= it.func; i_piece <= it.piece; i_square <= it.square;
                i_to_piece <= it.to_piece; i_to_square <= it.to_square;
                i_side_to_move <= it.stm; i_lane <= it.lane; i_neuron <= it.neuron;
                i_value <= it.value;
                i_in_valid <= 1'b1;
                sent_cnt++;
                if (--burst <= 0) begin
                    burst = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall pattern
    always @(negedge i_clk) begin
        if (mode_left <= 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 512);
        end
        mode_left--;
        case (mode)
            0: i_out_stall <= hold_off;
            1: i_out_stall <= hold_off || ($urandom_range(0, 9) < 3);
            2: i_out_stall <= hold_off || (cycles % 5 < 2);
            default: i_out_stall <= hold_off || ($urandom_range(0, 9) < 8);
        endcase
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (cycles == 150000) hold_cnt = 12000;
        hold_off = (hold_cnt > 0);
        if (hold_cnt > 0) hold_cnt--;
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("nnue_accumulator_and_evaluator_unit regression: fail");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            t_item it;
            it = '0;
            it.func = i_func; it.piece = i_piece; it.square = i_square;
            it.to_piece = i_to_piece; it.to_square = i_to_square; it.stm = i_side_to_move;
            it.lane = i_lane; it.neuron = i_neuron; it.value = i_value;
            predict(it);
            acc_cnt++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (score_q.size() == 0) begin
                report("unexpected score", o_score, 0);
            end else begin
                logic [31:0] want;
                want = score_q.pop_front();
                if (o_score !== want) report("score", o_score, want);
            end
        end
    end

    initial begin
        t_item sy;
        sy = '0;
        sy.sync = 1'b1;
        for (int i = 0; i < NACC; i++) begin
            wacc[i] = '0;
            bacc[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1;

        // load every entry that gets read
        for (int p = 0; p < PIECE_KINDS; p++)
            for (int s = 0; s < 4; s++)
                for (int l = 0; l < NACC; l++)
                    pend_q.push_back(wr_item(F_WR_FW, 4'(p), s[0] ? (s[1] ? 6'd63 : 6'd7)
                                             : (s[1] ? 6'd56 : 6'd0), 8'(l), 0,
                                             32'($urandom_range(0, 600)) - 300));
        for (int l = 0; l < NACC; l++)
            pend_q.push_back(wr_item(F_WR_FB, 0, 0, 8'(l), 0, $urandom));
        for (int n = 0; n < NHID; n++) begin
            for (int l = 0; l < 2 * NACC; l++)
                pend_q.push_back(wr_item(F_WR_HW, 0, 0, 8'(l), 4'(n), $urandom));
            pend_q.push_back(wr_item(F_WR_HB, 0, 0, 0, 4'(n), $urandom_range(0, 4000) - 2000));
            pend_q.push_back(wr_item(F_WR_OW, 0, 0, 0, 4'(n), $urandom));
        end
        pend_q.push_back(wr_item(F_WR_OB, 0, 0, 0, 0, 32'h7fffffff));

        // directed
        pend_q.push_back(op_item(F_EVAL, 0, 0, 0, 0, 0));
        pend_q.push_back(op_item(F_RESET, 0, 0, 0, 0, 0));
        pend_q.push_back(op_item(F_EVAL, 0, 0, 0, 0, 1));
        pend_q.push_back(op_item(F_ADD, 4'd0, 6'd0, 0, 0, 0));
        pend_q.push_back(op_item(F_ADD, 4'd11, 6'd63, 0, 0, 0));
        pend_q.push_back(op_item(F_ADD, 4'd15, 6'd45, 0, 0, 0));
        pend_q.push_back(op_item(F_REMOVE, 4'd12, 6'd18, 0, 0, 0));
        pend_q.push_back(op_item(F_EVAL, 0, 0, 0, 0, 0));
        pend_q.push_back(op_item(F_MOVE, 4'd5, 6'd7, 4'd6, 6'd56, 0));
        pend_q.push_back(op_item(F_MOVE, 4'd3, 6'd0, 4'd14, 6'd37, 0));
        pend_q.push_back(op_item(F_MOVE, 4'd13, 6'd21, 4'd9, 6'd63, 0));
        pend_q.push_back(op_item(F_REMOVE, 4'd11, 6'd63, 0, 0, 0));
        pend_q.push_back(wr_item(F_WR_FW, 4'd3, 6'd7, 8'd200, 0, 32'hffffffff));
        pend_q.push_back(wr_item(F_WR_FW, 4'd13, 6'd0, 8'd5, 0, 32'hffffffff));
        pend_q.push_back(wr_item(F_WR_FB, 0, 0, 8'd255, 0, 32'h00007fff));
        pend_q.push_back(wr_item(F_WR_OW, 0, 0, 0, 4'd15, 32'hffffff80));
        pend_q.push_back(wr_item(F_WR_OB, 0, 0, 0, 0, 32'h80000000));
        pend_q.push_back(op_item(4'd11, 0, 0, 0, 0, 0));
        pend_q.push_back(op_item(4'd15, 4'd15, 6'd63, 4'd15, 6'd63, 1));
        pend_q.push_back(op_item(F_EVAL, 0, 0, 0, 0, 1));
        pend_q.push_back(sy);

        // random
        for (int k = 0; k < 1900; k++) begin
            pend_q.push_back(rand_item());
            if (k % 300 == 299) pend_q.push_back(sy);
        end

        wait (pend_q.size() == 0 && acc_cnt == sent_cnt);
        wait (score_q.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("nnue_accumulator_and_evaluator_unit regression: pass");
        end else begin
            $display("nnue_accumulator_and_evaluator_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ nnue_accumulator_and_evaluator_unit.f @@
design/nae_pkg.sv
design/nae_ram.sv
design/nnue_accumulator_and_evaluator_unit.sv
verif/tb_nnue_accumulator_and_evaluator_unit.sv
